// ===== design/afa_pkg.sv =====
// shared types, codes and constants for the adaptive frame admission block
// no dependencies; imported by the top level, the stage modules and the testbench
package afa_pkg;

   localparam logic [1:0] FUNC_ARRIVAL = 2'd0;
   localparam logic [1:0] FUNC_SUCCESS = 2'd1;
   localparam logic [1:0] FUNC_NOBUF   = 2'd2;

   localparam logic [19:0] IV_RESET_US     = 20'd33333;
   localparam logic [19:0] BASE_CAP_US     = 20'd250000;
   localparam logic [19:0] COOLDOWN_CAP_US = 20'd1000000;
   localparam logic [2:0]  MAX_EXP         = 3'd4;
   localparam logic [7:0]  STREAK_MAX      = 8'd255;
   localparam logic [31:0] RECIP5_Q34      = 32'hCCCCCCCD;

   localparam logic [1:0] THR_ONE   = 2'd1;
   localparam logic [1:0] THR_TWO   = 2'd2;
   localparam logic [1:0] THR_THREE = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [47:0] event_time;
      logic [23:0] proc_time;
   } req_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [47:0] event_time;
      logic [23:0] avg;
      logic [7:0]  streak;
   } ema_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [47:0] event_time;
      logic [23:0] avg;
      logic [7:0]  streak;
      logic [24:0] margin;
      logic        fire;
      logic [2:0]  expo;
   } margin_type;

   typedef struct packed {
      logic        admit;
      logic [47:0] next_admit;
      logic [23:0] avg;
      logic [7:0]  streak;
   } rsp_type;

   typedef struct packed {
      logic load_ema;
      logic load_margin;
      logic load_rsp;
   } pipe_ctl_type;

   // floor(x / 5), exact for any x below 2^27
   function automatic logic [24:0] div5(input logic [26:0] x);
      logic [58:0] prod;
      prod = {32'd0, x} * {27'd0, RECIP5_Q34};
      return prod[58:34];
   endfunction

endpackage

// ===== design/adaptive_frame_admission.sv =====
// adaptive frame admission top level: input register, interval register,
// pipeline flow control; depends on afa_pkg and the three stage modules
//
//   channel | direction | handshake          | payload
//   req_    | in        | req_valid/req_stall | func, event time, proc time
//   rsp_    | out       | rsp_valid/rsp_stall | admit, next admit, avg, streak
//   csr_    | in        | csr_valid/csr_ready | frame interval (us)
//
// one transaction per cycle sustained while the output is not stalled; a taken request
// passes three stages after the input register before its result appears
// the average/streak loop in stage 1 and the next-admit loop in stage 3
// each feed their state register back combinationally, which sets the one-per-cycle rate
// synchronous reset clears state, valids and sets the interval to 33333 us
// stages hold while stalled; bubbles collapse, so the input keeps flowing
// while a finished result waits in the output register, until every stage is full
module adaptive_frame_admission (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [47:0] req_event_time_us,
   input  logic [23:0] req_proc_time_us,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_admit,
   output logic [47:0] rsp_next_admit_time_us,
   output logic [23:0] rsp_avg_proc_us,
   output logic [7:0]  rsp_nobuf_streak,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [19:0] csr_frame_interval_us
);
   import afa_pkg::*;

   logic [19:0]  interval_ff;
   logic         s0_valid_ff, s0_valid_in;
   logic         s1_valid_ff, s1_valid_in;
   logic         s2_valid_ff, s2_valid_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         out_free, s2_free, s1_free, s0_free, accept;
   req_type      req_ff;
   ema_type      ema;
   margin_type   mrg;
   rsp_type      rsp;
   pipe_ctl_type ctl;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= IV_RESET_US;
      end else if (csr_valid && csr_ready) begin
         interval_ff <= csr_frame_interval_us;
      end
   end

   always_comb begin
      out_free        = !rsp_valid_ff || !rsp_stall;
      ctl.load_rsp    = s2_valid_ff && out_free;
      s2_free         = !s2_valid_ff || out_free;
      ctl.load_margin = s1_valid_ff && s2_free;
      s1_free         = !s1_valid_ff || s2_free;
      ctl.load_ema    = s0_valid_ff && s1_free;
      s0_free         = !s0_valid_ff || s1_free;
      accept          = req_valid && s0_free;

      s0_valid_in  = accept || (s0_valid_ff && !ctl.load_ema);
      s1_valid_in  = ctl.load_ema || (s1_valid_ff && !ctl.load_margin);
      s2_valid_in  = ctl.load_margin || (s2_valid_ff && !ctl.load_rsp);
      rsp_valid_in = ctl.load_rsp || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff.func       <= req_func;
         req_ff.event_time <= req_event_time_us;
         req_ff.proc_time  <= req_proc_time_us;
      end
   end

   afa_ema_stage u_ema (
      .clock (clock),
      .reset (reset),
      .load  (ctl.load_ema),
      .req   (req_ff),
      .ema   (ema)
   );

   afa_margin_stage u_margin (
      .clock    (clock),
      .load     (ctl.load_margin),
      .interval (interval_ff),
      .ema      (ema),
      .mrg      (mrg)
   );

   afa_sched_stage u_sched (
      .clock    (clock),
      .reset    (reset),
      .load     (ctl.load_rsp),
      .interval (interval_ff),
      .mrg      (mrg),
      .rsp      (rsp)
   );

   assign req_stall              = !s0_free;
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_admit              = rsp.admit;
   assign rsp_next_admit_time_us = rsp.next_admit;
   assign rsp_avg_proc_us        = rsp.avg;
   assign rsp_nobuf_streak       = rsp.streak;

endmodule

// ===== design/afa_ema_stage.sv =====
// stage 1: running average of processing time and no-buffer streak
// depends on afa_pkg
module afa_ema_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  afa_pkg::req_type req,
   output afa_pkg::ema_type ema
);
   import afa_pkg::*;

   logic [23:0] avg_ff, avg_in;
   logic [7:0]  streak_ff, streak_in;
   logic [26:0] blend;
   logic [24:0] blend_div;
   ema_type     ema_ff, ema_in;

   always_comb begin
      blend     = {1'b0, avg_ff, 2'b00} + {3'd0, req.proc_time};
      blend_div = div5(blend);
      avg_in    = avg_ff;
      streak_in = streak_ff;
      unique case (req.func)
         FUNC_SUCCESS: begin
            streak_in = '0;
            // seed the average with the first sample
            avg_in    = (avg_ff == '0) ? req.proc_time : blend_div[23:0];
         end
         FUNC_NOBUF: begin
            streak_in = (streak_ff == STREAK_MAX) ? streak_ff : streak_ff + 8'd1;
         end
         default: begin
         end
      endcase
      ema_in.func       = req.func;
      ema_in.event_time = req.event_time;
      ema_in.avg        = avg_in;
      ema_in.streak     = streak_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff    <= '0;
         streak_ff <= '0;
      end else if (load) begin
         avg_ff    <= avg_in;
         streak_ff <= streak_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ema_ff <= ema_in;
      end
   end

   assign ema = ema_ff;

endmodule

// ===== design/afa_margin_stage.sv =====
// stage 2: safety margin avg*6/5, backoff threshold and exponent
// depends on afa_pkg
module afa_margin_stage (
   input  logic                clock,
   input  logic                load,
   input  logic [19:0]         interval,
   input  afa_pkg::ema_type    ema,
   output afa_pkg::margin_type mrg
);
   import afa_pkg::*;

   logic [26:0] avg6;
   logic [27:0] ten_avg;
   logic [23:0] thirteen_iv;
   logic [20:0] two_iv;
   logic [1:0]  thr;
   logic [7:0]  over;
   margin_type  mrg_ff, mrg_in;

   always_comb begin
      avg6        = {1'b0, ema.avg, 2'b00} + {2'b00, ema.avg, 1'b0};
      ten_avg     = {1'b0, ema.avg, 3'b000} + {3'b000, ema.avg, 1'b0};
      thirteen_iv = {1'b0, interval, 3'b000} + {2'b00, interval, 2'b00} + {4'd0, interval};
      two_iv      = {interval, 1'b0};

      priority if (ema.avg == '0 || interval == '0) begin
         thr = THR_THREE;
      end else if ({1'b0, ema.avg} >= {4'd0, two_iv}) begin
         thr = THR_ONE;
      end else if (ten_avg >= {4'd0, thirteen_iv}) begin
         thr = THR_TWO;
      end else begin
         thr = THR_THREE;
      end

      over = ema.streak - {6'd0, thr};

      mrg_in.func       = ema.func;
      mrg_in.event_time = ema.event_time;
      mrg_in.avg        = ema.avg;
      mrg_in.streak     = ema.streak;
      mrg_in.margin     = div5(avg6);
      mrg_in.fire       = ema.streak >= {6'd0, thr};
      if (ema.streak <= {6'd0, thr}) begin
         mrg_in.expo = '0;
      end else if (over > {5'd0, MAX_EXP}) begin
         mrg_in.expo = MAX_EXP;
      end else begin
         mrg_in.expo = over[2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mrg_ff <= mrg_in;
      end
   end

   assign mrg = mrg_ff;

endmodule

// ===== design/afa_sched_stage.sv =====
// stage 3: admit decision, next-admit scheduling and the result register
// depends on afa_pkg
module afa_sched_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic [19:0]         interval,
   input  afa_pkg::margin_type mrg,
   output afa_pkg::rsp_type    rsp
);
   import afa_pkg::*;

   logic [47:0] next_ff, next_in;
   logic [47:0] admitted_ff, admitted_in;
   logic        armed_ff, armed_in;
   logic [47:0] next_eff;
   logic        admit;
   logic [24:0] base_raw;
   logic [19:0] base;
   logic [23:0] shifted;
   logic [19:0] cooldown;
   logic [24:0] target;
   rsp_type     rsp_ff, rsp_in;

   always_comb begin
      base_raw = (mrg.avg != '0) ? mrg.margin : {4'd0, interval, 1'b0};
      // lower bound is tested first and wins over the cap
      if (base_raw < {5'd0, interval}) begin
         base = interval;
      end else if (base_raw > {5'd0, BASE_CAP_US}) begin
         base = BASE_CAP_US;
      end else begin
         base = base_raw[19:0];
      end
      shifted = {4'd0, base} << mrg.expo;
      if (shifted < {4'd0, interval}) begin
         cooldown = interval;
      end else if (shifted > {4'd0, COOLDOWN_CAP_US}) begin
         cooldown = COOLDOWN_CAP_US;
      end else begin
         cooldown = shifted[19:0];
      end
      target = (mrg.margin < {5'd0, interval}) ? {5'd0, interval} : mrg.margin;

      next_eff    = armed_ff ? next_ff : mrg.event_time;
      admit       = 1'b0;
      next_in     = next_ff;
      armed_in    = armed_ff;
      admitted_in = admitted_ff;
      unique case (mrg.func)
         FUNC_ARRIVAL: begin
            armed_in = 1'b1;
            next_in  = next_eff;
            if (mrg.event_time >= next_eff) begin
               admit       = 1'b1;
               admitted_in = mrg.event_time;
            end
         end
         FUNC_SUCCESS: begin
            next_in = admitted_ff + {23'd0, target};
         end
         FUNC_NOBUF: begin
            if (mrg.fire) begin
               next_in = admitted_ff + {28'd0, cooldown};
            end
         end
         default: begin
         end
      endcase

      rsp_in.admit      = admit;
      rsp_in.next_admit = next_in;
      rsp_in.avg        = mrg.avg;
      rsp_in.streak     = mrg.streak;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff     <= '0;
         admitted_ff <= '0;
         armed_ff    <= 1'b0;
      end else if (load) begin
         next_ff     <= next_in;
         admitted_ff <= admitted_in;
         armed_ff    <= armed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

// ===== design/afa_checker.sv =====
// port-level checks for adaptive_frame_admission, attached by bind
// depends on the top level's port list only
module afa_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_admit,
   input logic [47:0] rsp_next_admit_time_us,
   input logic [23:0] rsp_avg_proc_us,
   input logic [7:0]  rsp_nobuf_streak
);
   logic        rsp_take;
   logic [23:0] last_avg_ff;
   logic [7:0]  last_streak_ff;
   logic [7:0]  streak_bump;

   assign rsp_take    = rsp_valid && !rsp_stall;
   assign streak_bump = last_streak_ff + 8'd1;

   // values of the previous delivered result transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         last_avg_ff    <= '0;
         last_streak_ff <= '0;
      end else if (rsp_take) begin
         last_avg_ff    <= rsp_avg_proc_us;
         last_streak_ff <= rsp_nobuf_streak;
      end
   end

   // an admitted frame leaves average and streak alone
   a_admit_keeps_stats: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_admit |->
         rsp_avg_proc_us == last_avg_ff && rsp_nobuf_streak == last_streak_ff)
      else $error("admit changed average or streak");

   // streak holds, clears or steps by one between transactions
   a_streak_step: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> rsp_nobuf_streak == last_streak_ff ||
                   rsp_nobuf_streak == streak_bump || rsp_nobuf_streak == 8'd0)
      else $error("streak jumped");

   // a no-buffer report never admits and never moves the average
   a_nobuf_no_admit: assert property (@(posedge clock) disable iff (reset)
      rsp_take && last_streak_ff != 8'd255 && rsp_nobuf_streak == streak_bump |->
         !rsp_admit && rsp_avg_proc_us == last_avg_ff)
      else $error("no-buffer report admitted or changed average");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_admit) &&
         $stable(rsp_next_admit_time_us) && $stable(rsp_avg_proc_us) &&
         $stable(rsp_nobuf_streak))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind adaptive_frame_admission afa_checker u_afa_checker (.*);

// ===== bench/tb_adaptive_frame_admission.sv =====
`timescale 1ns / 100ps
// testbench for adaptive_frame_admission: directed and random frame/report transactions,
// checked against a built-in admission predictor; depends on afa_pkg and the design files
module tb_adaptive_frame_admission;
   import afa_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int unsigned HOLD_CYCLES = 60;

   class admission_checker;
      logic [19:0] interval;
      logic [23:0] avg;
      logic [47:0] next_admit;
      logic        armed;
      logic [7:0]  streak;
      logic [47:0] admitted;
      logic        last_admit;
      rsp_type     pending_decisions[$];
      int unsigned errors;
      int unsigned checked;
      int unsigned admits;

      function new();
         interval   = IV_RESET_US;
         avg        = '0;
         next_admit = '0;
         armed      = 1'b0;
         streak     = '0;
         admitted   = '0;
         last_admit = 1'b0;
         errors     = 0;
         checked    = 0;
         admits     = 0;
      endfunction

      // advance the admission state by one accepted request and queue its decision
      function void predict_decision(input logic [1:0] func, input logic [47:0] t,
                                     input logic [23:0] proc);
         logic [63:0] a, iv, s, th, base, sum;
         logic [1:0]  thr;
         rsp_type     dec;
         last_admit = 1'b0;
         iv = interval;
         case (func)
            FUNC_ARRIVAL: begin
               if (!armed) begin
                  next_admit = t;
                  armed = 1'b1;
               end
               if (t >= next_admit) begin
                  last_admit = 1'b1;
                  admitted = t;
                  admits++;
               end
            end
            FUNC_SUCCESS: begin
               streak = '0;
               a = avg;
               if (a == 0) a = proc;
               else a = (4 * a + proc) / 5;
               avg = a[23:0];
               a = avg;
               base = a * 6 / 5;
               if (base < iv) base = iv;
               sum = admitted + base;
               next_admit = sum[47:0];
            end
            FUNC_NOBUF: begin
               if (streak != STREAK_MAX) streak = streak + 8'd1;
               a = avg;
               s = streak;
               if (a == 0 || iv == 0) thr = THR_THREE;
               else if (a >= 2 * iv) thr = THR_ONE;
               else if (10 * a >= 13 * iv) thr = THR_TWO;
               else thr = THR_THREE;
               th = thr;
               if (s >= th) begin
                  base = (a != 0) ? a * 6 / 5 : 2 * iv;
                  // lower bound is tested first and wins when the bounds cross
                  if (base < iv) base = iv;
                  else if (base > BASE_CAP_US) base = BASE_CAP_US;
                  s = (s > th) ? s - th : 0;
                  if (s > MAX_EXP) s = MAX_EXP;
                  base = base << s;
                  if (base < iv) base = iv;
                  else if (base > COOLDOWN_CAP_US) base = COOLDOWN_CAP_US;
                  sum = admitted + base;
                  next_admit = sum[47:0];
               end
            end
            default: ;
         endcase
         dec.admit      = last_admit;
         dec.next_admit = next_admit;
         dec.avg        = avg;
         dec.streak     = streak;
         pending_decisions.push_back(dec);
      endfunction

      function void check_decision(input rsp_type got);
         rsp_type want;
         if (pending_decisions.size() == 0) begin
            errors++;
            $display("%0t: result with none expected, actual next admit %h", $time,
                     got.next_admit);
            return;
         end
         want = pending_decisions.pop_front();
         checked++;
         if (got.admit !== want.admit) begin
            errors++;
            $display("%0t: admit expected %0b actual %0b", $time, want.admit, got.admit);
         end
         if (got.next_admit !== want.next_admit) begin
            errors++;
            $display("%0t: next admit expected %h actual %h", $time, want.next_admit,
                     got.next_admit);
         end
         if (got.avg !== want.avg) begin
            errors++;
            $display("%0t: avg proc expected %h actual %h", $time, want.avg, got.avg);
         end
         if (got.streak !== want.streak) begin
            errors++;
            $display("%0t: streak expected %0d actual %0d", $time, want.streak, got.streak);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_func;
   logic [47:0] req_event_time_us;
   logic [23:0] req_proc_time_us;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_admit;
   logic [47:0] rsp_next_admit_time_us;
   logic [23:0] rsp_avg_proc_us;
   logic [7:0]  rsp_nobuf_streak;
   logic        csr_valid;
   logic        csr_ready;
   logic [19:0] csr_frame_interval_us;

   admission_checker decisions;
   logic        idle_on;
   logic        hold_go;
   int unsigned hold_left;
   int unsigned stall_left;
   int unsigned items_sent;
   int unsigned csr_writes;
   logic [47:0] stream_time;

   adaptive_frame_admission uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_event_time_us(req_event_time_us),
      .req_proc_time_us(req_proc_time_us),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_admit(rsp_admit),
      .rsp_next_admit_time_us(rsp_next_admit_time_us),
      .rsp_avg_proc_us(rsp_avg_proc_us),
      .rsp_nobuf_streak(rsp_nobuf_streak),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_frame_interval_us(csr_frame_interval_us)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("adaptive_frame_admission: mismatch");
      $finish;
   end

   // long receiver hold-off, counted here so the sender keeps going meanwhile
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_go) begin
         hold_left <= HOLD_CYCLES;
         hold_go <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 3);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         decisions.check_decision({rsp_admit, rsp_next_admit_time_us, rsp_avg_proc_us,
                                   rsp_nobuf_streak});
   end

   function automatic logic [47:0] rand48();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[47:0];
   endfunction

   function automatic logic [23:0] rand24();
      logic [31:0] w;
      w = $urandom;
      return w[23:0];
   endfunction

   // processing times spread around interval multiples so all thresholds get hit
   function automatic logic [23:0] pick_proc(input logic [63:0] iv);
      logic [63:0] v;
      case ($urandom_range(0, 9))
         0: v = rand24();
         1: v = 0;
         2: v = $urandom_range(1, 2000);
         default: v = iv * $urandom_range(5, 30) / 10 + $urandom_range(0, 50);
      endcase
      if (v > 64'hFFFFFF) v = 64'hFFFFFF;
      return v[23:0];
   endfunction

   task automatic send_item(input logic [1:0] func, input logic [47:0] t,
                            input logic [23:0] proc);
      req_valid <= 1'b1;
      req_func <= func;
      req_event_time_us <= t;
      req_proc_time_us <= proc;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decisions.predict_decision(func, t, proc);
      items_sent++;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (decisions.pending_decisions.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_interval(input logic [19:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_frame_interval_us <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      decisions.interval = value;
      csr_valid <= 1'b0;
      csr_writes++;
   endtask

   // a run of camera frames with the reports a pipeline would send back
   task automatic run_stream(input int unsigned frames);
      logic [63:0] iv, step;
      logic [47:0] gap;
      int unsigned n, r;
      iv = decisions.interval;
      case ($urandom_range(0, 9))
         0: stream_time = rand48();
         1: stream_time = 48'hFFFF_FFFF_FFFF - $urandom_range(0, 4_000_000);
         2: stream_time = decisions.next_admit - $urandom_range(0, 100_000);
         default: ;
      endcase
      for (n = 0; n < frames; n++) begin
         case ($urandom_range(0, 19))
            0: step = 0;
            1: begin
               gap = decisions.next_admit - stream_time;
               step = gap;
            end
            default: begin
               if (iv == 0) step = $urandom_range(1, 2000);
               else step = iv - iv / 16 + $urandom_range(0, iv / 8);
            end
         endcase
         stream_time = stream_time + step[47:0];
         send_item(FUNC_ARRIVAL, stream_time, rand24());
         if (decisions.last_admit) begin
            r = $urandom_range(0, 9);
            if (r < 6) begin
               send_item(FUNC_SUCCESS, rand48(), pick_proc(iv));
            end else if (r < 9) begin
               repeat ($urandom_range(1, 6)) send_item(FUNC_NOBUF, rand48(), rand24());
               if ($urandom_range(0, 1) == 1)
                  send_item(FUNC_SUCCESS, rand48(), pick_proc(iv));
            end
         end
         if ($urandom_range(0, 11) == 0)
            send_item(2'($urandom_range(0, 3)), rand48(), rand24());
      end
   endtask

   initial begin
      int unsigned ph, phase_end;
      logic [19:0] iv_value;
      decisions = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_ARRIVAL;
      req_event_time_us = '0;
      req_proc_time_us = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_frame_interval_us = IV_RESET_US;
      idle_on = 1'b1;
      hold_go = 1'b0;
      hold_left = 0;
      stall_left = 0;
      items_sent = 0;
      csr_writes = 0;
      stream_time = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reports before any frame, then arming, wrap of the next-admit time, unused code
      send_item(FUNC_SUCCESS, 48'd0, 24'd0);
      send_item(FUNC_NOBUF, 48'd0, 24'd0);
      send_item(FUNC_UNUSED, 48'hFFFF_FFFF_FFFF, 24'hFFFFFF);
      send_item(FUNC_ARRIVAL, 48'd0, 24'd0);
      send_item(FUNC_ARRIVAL, 48'd20000, 24'hFFFFFF);
      send_item(FUNC_SUCCESS, 48'd0, 24'hFFFFFF);
      send_item(FUNC_ARRIVAL, 48'd1000, 24'd0);
      repeat (6) send_item(FUNC_NOBUF, 48'hFFFF_FFFF_FFFF, 24'd0);
      send_item(FUNC_SUCCESS, 48'd0, 24'd0);
      send_item(FUNC_ARRIVAL, 48'hFFFF_FFFF_FFF0, 24'd0);
      send_item(FUNC_SUCCESS, 48'd0, 24'd40000);
      send_item(FUNC_ARRIVAL, 48'd5, 24'd0);
      repeat (3) send_item(FUNC_NOBUF, 48'd0, 24'hFFFFFF);
      send_item(FUNC_ARRIVAL, 48'hFFFF_FFFF_FFFF, 24'd0);
      send_item(FUNC_UNUSED, 48'd0, 24'd0);
      send_item(FUNC_SUCCESS, 48'd0, 24'd1);

      for (ph = 0; ph < 7; ph++) begin
         case (ph)
            0: iv_value = 20'd1000;
            1: iv_value = 20'd1000000;
            3: iv_value = 20'd0;
            4: iv_value = 20'hFFFFF;
            6: iv_value = IV_RESET_US;
            default: iv_value = 20'($urandom_range(1000, 1000000));
         endcase
         write_interval(iv_value);
         if (ph == 1) begin
            // fill the pipeline against a stalled output
            idle_on <= 1'b0;
            hold_go <= 1'b1;
            run_stream(20);
            idle_on <= 1'b1;
         end
         if (ph == 6) idle_on <= 1'b0;
         phase_end = items_sent + 120;
         while (items_sent < phase_end) run_stream($urandom_range(2, 12));
         if (ph == 0) repeat (260) send_item(FUNC_NOBUF, rand48(), rand24());
      end

      drain();
      $display("ran %0d requests, %0d results checked, %0d frames admitted", items_sent,
               decisions.checked, decisions.admits);
      $display("%0d interval writes from 0 to the 20-bit maximum, streak driven to saturation",
               csr_writes);
      if (decisions.errors == 0 && decisions.pending_decisions.size() == 0)
         $display("adaptive_frame_admission: match");
      else
         $display("adaptive_frame_admission: mismatch");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/afa_pkg.sv
design/afa_ema_stage.sv
design/afa_margin_stage.sv
design/afa_sched_stage.sv
design/adaptive_frame_admission.sv
design/afa_checker.sv
bench/tb_adaptive_frame_admission.sv
